/* hw/rtl/stw_pkg.sv */
// Package for the slotted timer wheel: widths, codes and request/result words.
// No dependencies.
package stw_pkg;
    localparam int SLOT_SHIFT = 3;
    localparam int NUM_SLOTS  = 128;
    localparam int NUM_TIMERS = 32;
    localparam int ID_W       = 5;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int TIDX_W     = $clog2(NUM_TIMERS);
    localparam int VCNT_W     = $clog2(NUM_SLOTS + 1);

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_DEL = 2'd1;
    localparam logic [1:0] REQ_CHK = 2'd2;
    localparam logic [1:0] REQ_NOP = 2'd3;

    localparam logic [1:0] RK_ADD  = 2'd0;
    localparam logic [1:0] RK_DEL  = 2'd1;
    localparam logic [1:0] RK_FIRE = 2'd2;
    localparam logic [1:0] RK_DONE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ARMED = 2'd1;
    localparam logic [1:0] ST_PAST  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [4:0]  timer_id;
        logic [31:0] expiry_time;
        logic [31:0] now_time;
    } t_req;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [4:0] fired_id;
        logic       was_armed;
        logic [1:0] add_status;
        logic [5:0] expired_count;
        logic       last_of_run;
    } t_res;

    function automatic logic time_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction
endpackage

/* hw/rtl/stw_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on stw_pkg.
interface stw_req_if;
    import stw_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface stw_res_if;
    import stw_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/stw_front.sv */
// Front end: drops unknown requests, queues the rest in a two-word FIFO.
// Depends on stw_pkg and stw_if.
module stw_front (
    input  logic i_clk,
    input  logic i_rst_n,
    stw_req_if.sink   i_req,
    stw_req_if.source o_q
);
    import stw_pkg::*;
    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push = i_req.valid && i_req.ready && (i_req.data.req_type != REQ_NOP);
    assign w_pop  = o_q.valid && o_q.ready;
    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_req.data;
    end
endmodule

/* hw/rtl/stw_back.sv */
// Back end: timer table, add/delete, and the slot walk of a check.
// Depends on stw_pkg and stw_if.
module stw_back (
    input  logic i_clk,
    input  logic i_rst_n,
    stw_req_if.sink   i_q,
    stw_res_if.source o_res
);
    import stw_pkg::*;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [NUM_TIMERS-1:0] r_armed;
    logic [31:0] r_exp [NUM_TIMERS];
    logic [15:0] r_seq [NUM_TIMERS];
    logic [15:0] r_ins;
    logic [31:0] r_last;
    logic [1:0]  r_st;
    logic [31:0] r_now, r_slot;
    logic [VCNT_W-1:0] r_vis;
    logic [TIDX_W:0]   r_i;
    logic        r_hit;
    logic [TIDX_W-1:0] r_best;
    logic [31:0] r_blate;
    logic [15:0] r_bage;
    logic [5:0]  r_cnt;
    logic        r_ov;
    t_res        r_out;

    logic        w_take, w_free;
    t_req        w_q;
    logic [TIDX_W-1:0] w_ci;
    logic [TIDX_W-1:0] w_tid;
    logic        w_cand;
    logic [31:0] w_late;
    logic [15:0] w_age;
    logic        w_id_ok;
    logic [1:0]  w_add_st;
    logic        w_was;
    logic        w_load;

    function automatic t_res res_word(input logic [1:0] kind, input logic [ID_W-1:0] id,
                                      input logic armed, input logic [1:0] st,
                                      input logic [5:0] cnt, input logic last);
        t_res r;
        r.result_kind   = kind;
        r.fired_id      = id;
        r.was_armed     = armed;
        r.add_status    = st;
        r.expired_count = cnt;
        r.last_of_run   = last;
        return r;
    endfunction

    assign w_q    = i_q.data;
    assign w_free = !r_ov || o_res.ready;
    assign i_q.ready = (r_st == S_IDLE) && w_free;
    assign w_take = i_q.valid && i_q.ready;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;
    assign w_id_ok = ({1'b0, w_q.timer_id} < 6'(NUM_TIMERS));
    assign w_tid   = w_q.timer_id[TIDX_W-1:0];

    assign w_add_st = (!w_id_ok || r_armed[w_tid]) ? ST_ARMED
                    : !time_after(w_q.expiry_time, w_q.now_time) ? ST_PAST : ST_OK;
    assign w_was    = w_id_ok && r_armed[w_tid];

    // a new word goes out on an ack, a fire or a done
    assign w_load = ((r_st == S_IDLE) && w_take && (w_q.req_type != REQ_CHK))
                 || ((r_st == S_PICK) && r_hit && w_free)
                 || ((r_st == S_DONE) && w_free);

    assign w_ci   = r_i[TIDX_W-1:0];
    assign w_late = r_now - r_exp[w_ci];
    assign w_age  = r_ins - r_seq[w_ci];
    assign w_cand = r_armed[w_ci]
        && (r_exp[w_ci][SLOT_SHIFT+SLOT_W-1:SLOT_SHIFT]
            == r_slot[SLOT_SHIFT+SLOT_W-1:SLOT_SHIFT])
        && !time_after(r_exp[w_ci], r_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= '0;
            r_ins <= '0;
            r_last <= '0;
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_ov <= w_load || (r_ov && !o_res.ready);
            case (r_st)
                S_IDLE: begin
                    if (w_take) begin
                        case (w_q.req_type)
                            REQ_ADD: begin
                                r_out <= res_word(RK_ADD, w_q.timer_id, 1'b0, w_add_st,
                                                  6'd0, 1'b1);
                                if (w_add_st == ST_OK) begin
                                    r_armed[w_tid] <= 1'b1;
                                    r_exp[w_tid] <= w_q.expiry_time;
                                    r_seq[w_tid] <= r_ins;
                                    r_ins <= r_ins + 16'd1;
                                end
                            end
                            REQ_DEL: begin
                                r_out <= res_word(RK_DEL, w_q.timer_id, w_was, ST_OK,
                                                  6'd0, 1'b1);
                                if (w_was) r_armed[w_tid] <= 1'b0;
                            end
                            default: begin
                                r_now <= w_q.now_time;
                                r_slot <= {w_q.now_time[31:SLOT_SHIFT], {SLOT_SHIFT{1'b0}}};
                                r_vis <= '0;
                                r_cnt <= '0;
                                r_i <= '0;
                                r_hit <= 1'b0;
                                r_st <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // stop once past the last checked slot or after a full turn
                    if (r_vis == VCNT_W'(NUM_SLOTS) || (r_slot - r_last) >= 32'h8000_0000) begin
                        r_st <= S_DONE;
                    end else if (r_i == (TIDX_W+1)'(NUM_TIMERS)) begin
                        r_st <= S_PICK;
                    end else begin
                        if (w_cand && (!r_hit || w_late > r_blate
                                || (w_late == r_blate && w_age > r_bage))) begin
                            r_hit <= 1'b1;
                            r_best <= w_ci;
                            r_blate <= w_late;
                            r_bage <= w_age;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                S_PICK: begin
                    if (!r_hit) begin
                        r_slot <= r_slot - (32'd1 << SLOT_SHIFT);
                        r_vis <= r_vis + 1'b1;
                        r_i <= '0;
                        r_st <= S_SCAN;
                    end else if (w_free) begin
                        r_out <= res_word(RK_FIRE, ID_W'(r_best), 1'b0, ST_OK, 6'd0, 1'b0);
                        r_armed[r_best] <= 1'b0;
                        r_cnt <= r_cnt + 6'd1;
                        r_hit <= 1'b0;
                        r_i <= '0;
                        r_st <= S_SCAN;
                    end
                end
                default: begin
                    if (w_free) begin
                        r_out <= res_word(RK_DONE, '0, 1'b0, ST_OK, r_cnt, 1'b1);
                        r_last <= {r_now[31:SLOT_SHIFT], {SLOT_SHIFT{1'b0}}};
                        r_st <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule

/* hw/rtl/slotted_timer_wheel_top.sv */
// Slotted timer wheel, top level.
// Request channel i_req carries req_type, timer_id, expiry_time, now_time;
// result channel o_res carries one word per result (acks, fires, done).
// A front FIFO of two words decouples request intake from the back end.
// Add and delete give one ack each, held in the back end's output register;
// with the receiver ready the back end takes one add or delete a cycle.
// A check scans all 32 timer entries per slot, one entry a cycle in the
// back end's sequencer, rescans the slot after each fired timer, visits
// up to 128 slots and then sends the done word.
// The back end takes no new request until the done word is out.
// Reset (synchronous, active low) disarms all timers, clears the insert
// counter and the last checked slot time. When the receiver stalls the
// output register holds its word, the back end waits, and the front FIFO
// fills and then drops ready. Unknown request codes are discarded.
// Depends on stw_pkg, stw_if, stw_front, stw_back.
module slotted_timer_wheel_top (
    input  logic i_clk,
    input  logic i_rst_n,
    stw_req_if.sink   i_req,
    stw_res_if.source o_res
);
    import stw_pkg::*;
    stw_req_if u_q ();

    stw_front u_front (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .o_q(u_q.source));
    stw_back  u_back  (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_q(u_q.sink), .o_res(o_res));
endmodule

/* tb/sv/tb_slotted_timer_wheel_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for slotted_timer_wheel_top: adds, deletes and expiry checks
// with random idling on both channels, checked against an in-bench model of the wheel.
// Depends on stw_pkg, stw_if and the slotted_timer_wheel_top RTL.
module tb_slotted_timer_wheel_top;
    import stw_pkg::*;

    logic i_clk;
    logic i_rst_n;

    stw_req_if req_ch ();
    stw_res_if res_ch ();

    slotted_timer_wheel_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_res  (res_ch.source)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // wheel shadow state
    logic        wh_armed [NUM_TIMERS];
    logic [31:0] wh_expiry[NUM_TIMERS];
    logic [15:0] wh_seq   [NUM_TIMERS];
    logic [15:0] wh_ins_cnt;
    logic [31:0] wh_last_slot;

    t_req pending_reqs[$];
    t_res expected_res[$];
    int   n_sent;
    int   n_results;
    int   n_fired;
    int   n_errors;

    function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && (d < 32'h8000_0000);
    endfunction

    function automatic t_res make_res(input logic [1:0] kind, input logic [4:0] id,
                                      input logic armed, input logic [1:0] st,
                                      input logic [5:0] cnt, input logic last);
        t_res r;
        r.result_kind   = kind;
        r.fired_id      = id;
        r.was_armed     = armed;
        r.add_status    = st;
        r.expired_count = cnt;
        r.last_of_run   = last;
        return r;
    endfunction

    // Fire expired timers of one slot, most overdue first, oldest first on ties.
    function automatic int fire_slot(input logic [6:0] slot, input logic [31:0] now);
        int          n;
        int          best;
        logic [31:0] best_late;
        logic [15:0] best_age;
        logic [31:0] late;
        logic [15:0] age;
        n = 0;
        forever begin
            best = -1;
            best_late = '0;
            best_age = '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (wh_armed[i] && wh_expiry[i][9:3] == slot
                    && !later_than(wh_expiry[i], now)) begin
                    late = now - wh_expiry[i];
                    age = wh_ins_cnt - wh_seq[i];
                    if (best < 0 || late > best_late || (late == best_late && age > best_age)) begin
                        best = i;
                        best_late = late;
                        best_age = age;
                    end
                end
            end
            if (best < 0) break;
            wh_armed[best] = 1'b0;
            expected_res.push_back(make_res(RK_FIRE, best[4:0], 1'b0, ST_OK, 6'd0, 1'b0));
            n++;
        end
        return n;
    endfunction

    function automatic void predict_wheel(input t_req rq);
        logic [1:0]  st;
        logic        was;
        int          k;
        logic [31:0] walk_slot;
        case (rq.req_type)
            REQ_ADD: begin
                if (wh_armed[rq.timer_id]) st = ST_ARMED;
                else if (!later_than(rq.expiry_time, rq.now_time)) st = ST_PAST;
                else begin
                    st = ST_OK;
                    wh_armed[rq.timer_id] = 1'b1;
                    wh_expiry[rq.timer_id] = rq.expiry_time;
                    wh_seq[rq.timer_id] = wh_ins_cnt;
                    wh_ins_cnt = wh_ins_cnt + 16'd1;
                end
                expected_res.push_back(make_res(RK_ADD, rq.timer_id, 1'b0, st, 6'd0, 1'b1));
            end
            REQ_DEL: begin
                was = wh_armed[rq.timer_id];
                wh_armed[rq.timer_id] = 1'b0;
                expected_res.push_back(make_res(RK_DEL, rq.timer_id, was, ST_OK, 6'd0, 1'b1));
            end
            REQ_CHK: begin
                k = 0;
                walk_slot = {rq.now_time[31:3], 3'b000};
                for (int v = 0; v < NUM_SLOTS; v++) begin
                    if (walk_slot - wh_last_slot >= 32'h8000_0000) break;
                    k += fire_slot(walk_slot[9:3], rq.now_time);
                    walk_slot = walk_slot - 32'd8;
                end
                wh_last_slot = {rq.now_time[31:3], 3'b000};
                n_fired += k;
                expected_res.push_back(make_res(RK_DONE, 5'd0, 1'b0, ST_OK, k[5:0], 1'b1));
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_req(input logic [1:0] rt, input logic [4:0] id,
                                      input logic [31:0] exp_t, input logic [31:0] now_t);
        t_req rq;
        rq.req_type = rt;
        rq.timer_id = id;
        rq.expiry_time = exp_t;
        rq.now_time = now_t;
        pending_reqs.push_back(rq);
    endfunction

    function automatic int phase_of(input int n);
        return (n < 60) ? 0 : (n < 120) ? 1 : 2;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 &&
                $urandom_range(99) >= ((phase_of(n_sent) == 0) ? 19 :
                                       (phase_of(n_sent) == 1) ? 77 : 0)) begin
                t_req rq;
                rq = pending_reqs.pop_front();
                predict_wheel(rq);
                n_sent++;
                req_ch.data  <= rq;
                req_ch.valid <= 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= $urandom_range(99) >= ((phase_of(n_sent) == 0) ? 77 :
                                                   (phase_of(n_sent) == 1) ? 19 : 0);
            if (res_ch.valid && res_ch.ready) begin
                n_results++;
                if (expected_res.size() == 0) begin
                    $display("%0t: unexpected word expected none actual %p", $time,
                             res_ch.data);
                    n_errors++;
                end else begin
                    t_res e;
                    e = expected_res.pop_front();
                    if (e.result_kind !== res_ch.data.result_kind) begin
                        $display("%0t: result_kind expected %0d actual %0d", $time,
                                 e.result_kind, res_ch.data.result_kind);
                        n_errors++;
                    end
                    if (e.fired_id !== res_ch.data.fired_id) begin
                        $display("%0t: fired_id expected %0d actual %0d", $time,
                                 e.fired_id, res_ch.data.fired_id);
                        n_errors++;
                    end
                    if (e.was_armed !== res_ch.data.was_armed) begin
                        $display("%0t: was_armed expected %0d actual %0d", $time,
                                 e.was_armed, res_ch.data.was_armed);
                        n_errors++;
                    end
                    if (e.add_status !== res_ch.data.add_status) begin
                        $display("%0t: add_status expected %0d actual %0d", $time,
                                 e.add_status, res_ch.data.add_status);
                        n_errors++;
                    end
                    if (e.expired_count !== res_ch.data.expired_count) begin
                        $display("%0t: expired_count expected %0d actual %0d", $time,
                                 e.expired_count, res_ch.data.expired_count);
                        n_errors++;
                    end
                    if (e.last_of_run !== res_ch.data.last_of_run) begin
                        $display("%0t: last_of_run expected %0d actual %0d", $time,
                                 e.last_of_run, res_ch.data.last_of_run);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin
        #1_000_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [31:0] cur_now;
        int          pick;
        logic [4:0]  id;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            wh_armed[i] = 1'b0;
            wh_expiry[i] = '0;
            wh_seq[i] = '0;
        end
        wh_ins_cnt = '0;
        wh_last_slot = '0;
        n_sent = 0;
        n_results = 0;
        n_fired = 0;
        n_errors = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        res_ch.ready = 1'b0;

        // directed part
        queue_req(REQ_ADD, 5'd0, 32'hFFFF_FFFF, 32'd0);       // wraps to the past
        queue_req(REQ_ADD, 5'd31, 32'h0000_0010, 32'd0);
        queue_req(REQ_ADD, 5'd31, 32'h0000_0018, 32'd0);      // already armed
        queue_req(REQ_ADD, 5'd1, 32'd5, 32'd5);               // expiry equals now
        queue_req(REQ_DEL, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(REQ_DEL, 5'd31, 32'd0, 32'd0);              // not armed
        queue_req(REQ_ADD, 5'd2, 32'd8, 32'd0);
        queue_req(REQ_ADD, 5'd3, 32'd12, 32'd0);
        queue_req(REQ_ADD, 5'd4, 32'd12, 32'd0);              // tie with timer 3
        queue_req(REQ_ADD, 5'd5, 32'd30, 32'd0);              // same slot as check, later
        queue_req(REQ_CHK, 5'd0, 32'd0, 32'd27);
        queue_req(REQ_NOP, 5'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // ignored
        queue_req(REQ_ADD, 5'd6, 32'h0001_0000, 32'd27);
        queue_req(REQ_CHK, 5'd0, 32'd0, 32'h0010_0000);       // gap beyond the wheel
        queue_req(REQ_CHK, 5'd0, 32'd0, 32'hFFFF_FFFF);       // far behind, visits none
        queue_req(REQ_CHK, 5'd0, 32'd0, 32'hFFFF_FF00);
        cur_now = 32'hFFFF_FF00;

        // random part: mostly future adds and short steps of time
        for (int n = 0; n < 180; n++) begin
            pick = $urandom_range(99);
            id = 5'($urandom_range(31));
            if (pick < 45) begin
                queue_req(REQ_ADD, id, cur_now + $urandom_range(1, 300), cur_now);
            end else if (pick < 52) begin
                queue_req(REQ_ADD, id, $urandom, $urandom);
            end else if (pick < 57) begin
                queue_req(REQ_ADD, id, cur_now - $urandom_range(0, 20), cur_now);
            end else if (pick < 70) begin
                queue_req(REQ_DEL, id, $urandom, $urandom);
            end else if (pick < 97) begin
                cur_now = cur_now + (($urandom_range(9) == 0) ? $urandom_range(2000)
                                                               : $urandom_range(60));
                queue_req(REQ_CHK, id, $urandom, cur_now);
            end else begin
                queue_req(REQ_NOP, id, $urandom, $urandom);
            end
        end
        cur_now = cur_now + 32'd400;
        queue_req(REQ_CHK, 5'd0, 32'd0, cur_now);             // flush what is left

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || req_ch.valid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (expected_res.size() > 0) begin
            $display("%0t: %0d results never arrived", $time, expected_res.size());
            n_errors++;
        end

        $display("Sent %0d requests, checked %0d result words, %0d timers fired.",
                 n_sent, n_results, n_fired);
        $display("Covered wrap of time, ties, long gaps and three idling mixes.");
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/stw_pkg.sv
hw/rtl/stw_if.sv
hw/rtl/stw_front.sv
hw/rtl/stw_back.sv
hw/rtl/slotted_timer_wheel_top.sv
tb/sv/tb_slotted_timer_wheel_top.sv
